>>> rtl/hcbd_pkg.sv
package hcbd_pkg;

  // Width of a parsed chunk length; a digit that needs more bits is an error.
  localparam int SIZE_WIDTH = 32;

  localparam int BYTE_W      = 8;
  localparam int LINE_W      = 8;
  localparam int TRAILER_LEN = 2;
  localparam int TRAILER_W   = $clog2(TRAILER_LEN + 1);

  // Bytes, the CR included, that must come before the LF of a line end.
  localparam int MIN_LINE_BYTES = 2;

  localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0d;
  localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0a;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHUNK_MODE   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LINE_LEN = 1'd1;

  localparam logic              CHUNK_MODE_RESET   = 1'b1;
  localparam logic [LINE_W-1:0] MAX_LINE_LEN_RESET = 8'd16;

  typedef struct packed {
    logic              chunk_mode;
    logic [LINE_W-1:0] max_line_len;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              body_start;
  } raw_beat_t;

  // Contents of the input register handed to the decode stage.
  typedef struct packed {
    logic      valid;
    raw_beat_t beat;
  } stage_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              chunk_last;
    logic              zero_chunk;
    logic              parse_error;
  } dec_beat_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_digit(input logic [BYTE_W-1:0] b);
    hex_digit_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r.value = 4'(b - 8'h30);
    end else if (b inside {[8'h61:8'h66]}) begin
      r.value = 4'(b - 8'h57);
    end else if (b inside {[8'h41:8'h46]}) begin
      r.value = 4'(b - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // Space, tab, LF, VT, FF and CR.
  function automatic logic is_space(input logic [BYTE_W-1:0] b);
    return (b == 8'h20) || (b inside {[8'h09:8'h0d]});
  endfunction

endpackage

>>> rtl/hcbd_raw_if.sv
interface hcbd_raw_if;
  logic                            valid;
  logic                            ready;
  logic [hcbd_pkg::BYTE_W-1:0]     in_byte;
  logic                            body_start;

  modport source (output valid, output in_byte, output body_start, input ready);
  modport sink   (input valid, input in_byte, input body_start, output ready);
endinterface

>>> rtl/hcbd_dec_if.sv
interface hcbd_dec_if;
  logic                            valid;
  logic                            ready;
  logic [hcbd_pkg::BYTE_W-1:0]     data_byte;
  logic                            chunk_last;
  logic                            zero_chunk;
  logic                            parse_error;

  modport source (output valid, output data_byte, output chunk_last, output zero_chunk,
                  output parse_error, input ready);
  modport sink   (input valid, input data_byte, input chunk_last, input zero_chunk,
                  input parse_error, output ready);
endinterface

>>> rtl/hcbd_in_stage.sv
// Input register: holds one raw beat until the decode stage takes it.
module hcbd_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  hcbd_raw_if.sink             raw,
  input  logic                 take,
  output hcbd_pkg::stage_t     stage
);

  logic                  valid;
  hcbd_pkg::raw_beat_t   beat;

  assign raw.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (raw.valid && raw.ready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (raw.valid && raw.ready) begin
      beat.in_byte    <= raw.in_byte;
      beat.body_start <= raw.body_start;
    end
  end

  assign stage.valid = valid;
  assign stage.beat  = beat;

endmodule

>>> rtl/hcbd_core.sv
// Decode stage: parse state, one byte step and the result register.
module hcbd_core (
  input  logic                 clk,
  input  logic                 rst,
  input  hcbd_pkg::stage_t     stage,
  input  hcbd_pkg::cfg_t       cfg,
  output logic                 take,
  hcbd_dec_if.source           dec
);

  localparam int SW = hcbd_pkg::SIZE_WIDTH;

  typedef enum logic {PH_SIZE, PH_DATA} phase_t;

  phase_t                            phase, phase_next, cur_phase;
  logic [SW-1:0]                     hex_value, hex_value_next, cur_hex;
  logic                              digits_seen, digits_seen_next, cur_seen;
  logic                              digits_stopped, digits_stopped_next, cur_stop;
  logic [hcbd_pkg::LINE_W-1:0]       line_count, line_count_next, cur_count;
  logic                              prev_was_cr, prev_was_cr_next, cur_cr;
  logic [SW-1:0]                     payload_left, payload_left_next, cur_payload;
  logic [hcbd_pkg::TRAILER_W-1:0]    trailer_left, trailer_left_next, cur_trailer;
  logic                              error_held, error_held_next, cur_error;

  logic                              out_valid;
  hcbd_pkg::dec_beat_t               out_beat;
  logic                              emit;
  hcbd_pkg::dec_beat_t               res;

  logic [hcbd_pkg::BYTE_W-1:0]       b;
  logic [hcbd_pkg::LINE_W:0]         count;
  hcbd_pkg::hex_digit_t              hd;
  logic                              overflow;

  assign take = stage.valid && (!out_valid || dec.ready);
  assign b    = stage.beat.in_byte;
  assign hd   = hcbd_pkg::hex_digit(b);

  // A body start clears everything, including a held error, before the byte.
  always_comb begin
    if (stage.beat.body_start) begin
      cur_phase   = PH_SIZE;
      cur_hex     = '0;
      cur_seen    = 1'b0;
      cur_stop    = 1'b0;
      cur_count   = '0;
      cur_cr      = 1'b0;
      cur_payload = '0;
      cur_trailer = '0;
      cur_error   = 1'b0;
    end else begin
      cur_phase   = phase;
      cur_hex     = hex_value;
      cur_seen    = digits_seen;
      cur_stop    = digits_stopped;
      cur_count   = line_count;
      cur_cr      = prev_was_cr;
      cur_payload = payload_left;
      cur_trailer = trailer_left;
      cur_error   = error_held;
    end
  end

  assign count = {1'b0, cur_count} + (hcbd_pkg::LINE_W + 1)'(1);

  always_comb begin
    phase_next          = cur_phase;
    hex_value_next      = cur_hex;
    digits_seen_next    = cur_seen;
    digits_stopped_next = cur_stop;
    line_count_next     = cur_count;
    prev_was_cr_next    = cur_cr;
    payload_left_next   = cur_payload;
    trailer_left_next   = cur_trailer;
    error_held_next     = cur_error;
    emit                = 1'b0;
    res                 = '0;
    overflow            = 1'b0;

    if (cfg.chunk_mode && !cur_error) begin
      if (cur_phase == PH_DATA) begin
        if (cur_payload != '0) begin
          emit              = 1'b1;
          res.data_byte     = b;
          res.chunk_last    = (cur_payload == SW'(1));
          payload_left_next = cur_payload - SW'(1);
        end else begin
          // Trailer bytes are dropped unchecked.
          trailer_left_next = cur_trailer - hcbd_pkg::TRAILER_W'(1);
          if (cur_trailer == hcbd_pkg::TRAILER_W'(1)) begin
            phase_next = PH_SIZE;
          end
        end
      end else if (b == hcbd_pkg::BYTE_LF && cur_cr &&
                   cur_count >= hcbd_pkg::LINE_W'(hcbd_pkg::MIN_LINE_BYTES)) begin
        payload_left_next   = cur_hex;
        trailer_left_next   = hcbd_pkg::TRAILER_W'(hcbd_pkg::TRAILER_LEN);
        phase_next          = PH_DATA;
        hex_value_next      = '0;
        digits_seen_next    = 1'b0;
        digits_stopped_next = 1'b0;
        line_count_next     = '0;
        prev_was_cr_next    = 1'b0;
        if (cur_hex == '0) begin
          emit           = 1'b1;
          res.zero_chunk = 1'b1;
        end
      end else begin
        if (!cur_stop) begin
          if (hd.ok) begin
            if (cur_hex[SW-1:SW-4] != 4'd0) begin
              overflow = 1'b1;
            end else begin
              hex_value_next   = {cur_hex[SW-5:0], hd.value};
              digits_seen_next = 1'b1;
            end
          end else if (cur_seen || !hcbd_pkg::is_space(b)) begin
            digits_stopped_next = 1'b1;
          end
        end
        if (overflow) begin
          error_held_next = 1'b1;
          emit            = 1'b1;
          res.parse_error = 1'b1;
        end else begin
          prev_was_cr_next = (b == hcbd_pkg::BYTE_CR);
          if (count >= {1'b0, cfg.max_line_len}) begin
            error_held_next = 1'b1;
            emit            = 1'b1;
            res.parse_error = 1'b1;
          end else begin
            line_count_next = count[hcbd_pkg::LINE_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SIZE;
      hex_value      <= '0;
      digits_seen    <= 1'b0;
      digits_stopped <= 1'b0;
      line_count     <= '0;
      prev_was_cr    <= 1'b0;
      payload_left   <= '0;
      trailer_left   <= '0;
      error_held     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (take) begin
        phase          <= phase_next;
        hex_value      <= hex_value_next;
        digits_seen    <= digits_seen_next;
        digits_stopped <= digits_stopped_next;
        line_count     <= line_count_next;
        prev_was_cr    <= prev_was_cr_next;
        payload_left   <= payload_left_next;
        trailer_left   <= trailer_left_next;
        error_held     <= error_held_next;
      end
      if (take && emit) begin
        out_valid <= 1'b1;
      end else if (dec.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_beat <= res;
    end
  end

  assign dec.valid       = out_valid;
  assign dec.data_byte   = out_beat.data_byte;
  assign dec.chunk_last  = out_beat.chunk_last;
  assign dec.zero_chunk  = out_beat.zero_chunk;
  assign dec.parse_error = out_beat.parse_error;

endmodule

>>> rtl/http_chunked_body_decoder.sv
// Chunked body decoder. Raw body bytes enter on the raw channel, one byte per
// beat, and decoded beats leave on the dec channel: payload bytes with the last
// byte of each chunk marked, a single beat for a zero-length chunk, and a single
// error beat when a size line runs past max_line_len or its hex length does not
// fit in SIZE_WIDTH bits. After an error every byte is dropped until a beat with
// body_start set. The block takes one byte every cycle as long as the dec side
// keeps up. An accepted byte waits in the input register until the decode stage
// takes it, then updates the parse state and, if the byte yields a beat, loads
// the result register in the same step. The output register holds a waiting
// result while the next byte is already taken into the input register.
module http_chunked_body_decoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [hcbd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [hcbd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  hcbd_raw_if.sink                             raw,
  hcbd_dec_if.source                           dec
);

  hcbd_pkg::cfg_t    cfg;
  hcbd_pkg::stage_t  stage;
  logic              take;

  // Configuration registers. They are to be written only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chunk_mode   <= hcbd_pkg::CHUNK_MODE_RESET;
      cfg.max_line_len <= hcbd_pkg::MAX_LINE_LEN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        hcbd_pkg::CFG_CHUNK_MODE:   cfg.chunk_mode   <= cfg_wdata[0];
        hcbd_pkg::CFG_MAX_LINE_LEN: cfg.max_line_len <= cfg_wdata[hcbd_pkg::LINE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The input register frees itself whenever the decode stage takes its beat.
  hcbd_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .raw   (raw),
    .take  (take),
    .stage (stage)
  );

  // The decode stage holds all parse state and the result register. It takes
  // a beat whenever the result register is empty or is being drained.
  hcbd_core u_core (
    .clk   (clk),
    .rst   (rst),
    .stage (stage),
    .cfg   (cfg),
    .take  (take),
    .dec   (dec)
  );

endmodule

>>> dv/tb.sv
module tb;
  import hcbd_pkg::*;

  // The raw side takes one body byte per beat. The dec side returns payload
  // bytes, zero-length chunk marks and error marks, at most one beat per byte.
  localparam int HOLD_CYCLES = 80;
  localparam logic [7:0] BLANKS [4] = '{8'h20, 8'h09, 8'h0b, 8'h0c};

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  hcbd_raw_if raw ();
  hcbd_dec_if dec ();

  http_chunked_body_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .raw       (raw),
    .dec       (dec)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Percent of cycles in which the byte sender or the beat receiver sits idle.
  int src_idle_pct = 26;
  int snk_idle_pct = 53;
  // Set while the receiver is held off on purpose to fill the block up.
  logic rx_hold;
  // The next byte sent carries body_start, which realigns the parser.
  bit restart_next;
  int bytes_sent;
  int n_fail;
  string crlf = "\015\012";

  // Decoded beats that the parser model says must still come out, oldest first.
  dec_beat_t beats_due[$];

  // ---------------------------------------------------------------------------
  // Parser model. It keeps its own copy of the registers and of the parse state
  // and is stepped once for every byte the block accepts.
  // ---------------------------------------------------------------------------
  logic                  mode_on;
  logic [7:0]            line_limit;
  logic                  in_data;     // payload and trailer, else size line
  logic [SIZE_WIDTH-1:0] size_acc;    // chunk length parsed so far
  logic                  got_digit;
  logic                  digits_over; // a non-hex byte closed the digit run
  logic [7:0]            line_bytes;
  logic                  saw_cr;
  logic [SIZE_WIDTH:0]   body_to_go;  // payload plus the two trailer bytes
  logic [SIZE_WIDTH-1:0] data_to_go;
  logic                  err_sticky;

  function automatic int nibble_of(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h57;
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h37;
    return -1;
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  task automatic restart_line();
    size_acc    = '0;
    got_digit   = 1'b0;
    digits_over = 1'b0;
    line_bytes  = '0;
    saw_cr      = 1'b0;
  endtask

  task automatic restart_body();
    in_data    = 1'b0;
    restart_line();
    body_to_go = '0;
    data_to_go = '0;
    err_sticky = 1'b0;
  endtask

  task automatic flag_error();
    err_sticky = 1'b1;
    beats_due.push_back(dec_beat_t'{data_byte: 8'h00, chunk_last: 1'b0,
                                    zero_chunk: 1'b0, parse_error: 1'b1});
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic start);
    logic [8:0] count;
    int         nib;
    if (start) restart_body();
    if (!mode_on || err_sticky) return;

    if (in_data) begin
      if (data_to_go != '0) begin
        beats_due.push_back(dec_beat_t'{data_byte: b, chunk_last: data_to_go == 1,
                                        zero_chunk: 1'b0, parse_error: 1'b0});
        data_to_go--;
      end
      // The two trailer bytes are counted down but never looked at.
      if (body_to_go != '0) body_to_go--;
      if (body_to_go == '0) begin
        in_data = 1'b0;
        restart_line();
      end
      return;
    end

    count = {1'b0, line_bytes} + 9'd1;
    // CR LF closes the line only when something came before the CR.
    if (b == BYTE_LF && saw_cr && line_bytes >= 8'd2) begin
      data_to_go = size_acc;
      body_to_go = {1'b0, size_acc} + (SIZE_WIDTH + 1)'(2);
      in_data    = 1'b1;
      restart_line();
      if (data_to_go == '0) begin
        beats_due.push_back(dec_beat_t'{data_byte: 8'h00, chunk_last: 1'b0,
                                        zero_chunk: 1'b1, parse_error: 1'b0});
      end
      return;
    end

    if (!digits_over) begin
      nib = nibble_of(b);
      if (nib >= 0) begin
        // One more digit would not fit in SIZE_WIDTH bits.
        if ((size_acc >> (SIZE_WIDTH - 4)) != '0) begin
          flag_error();
          return;
        end
        size_acc  = {size_acc[SIZE_WIDTH-5:0], nib[3:0]};
        got_digit = 1'b1;
      end else if (got_digit || !is_blank(b)) begin
        digits_over = 1'b1;
      end
    end

    saw_cr = (b == BYTE_CR);
    if (count >= {1'b0, line_limit}) begin
      flag_error();
      return;
    end
    line_bytes = count[7:0];
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, a long hold-off on request, and the beat checker.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    dec.ready <= !rx_hold && ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    dec_beat_t want;
    if (!rst && dec.valid && dec.ready) begin
      if (beats_due.size() == 0) begin
        $error("beat with nothing due: data_byte %h chunk_last %b zero_chunk %b parse_error %b",
               dec.data_byte, dec.chunk_last, dec.zero_chunk, dec.parse_error);
        n_fail++;
      end else begin
        want = beats_due.pop_front();
        if (dec.data_byte !== want.data_byte) begin
          $error("data_byte: expected %h, got %h", want.data_byte, dec.data_byte);
          n_fail++;
        end
        if (dec.chunk_last !== want.chunk_last) begin
          $error("chunk_last: expected %b, got %b", want.chunk_last, dec.chunk_last);
          n_fail++;
        end
        if (dec.zero_chunk !== want.zero_chunk) begin
          $error("zero_chunk: expected %b, got %b", want.zero_chunk, dec.zero_chunk);
          n_fail++;
        end
        if (dec.parse_error !== want.parse_error) begin
          $error("parse_error: expected %b, got %b", want.parse_error, dec.parse_error);
          n_fail++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Offers one byte, with random idle cycles ahead of it, and steps the parser
  // model at the edge where the beat is taken. Valid stays high between
  // back-to-back beats.
  task automatic send_byte(input logic [7:0] b, input logic start);
    logic first;
    first = start || restart_next;
    restart_next = 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      raw.valid <= 1'b0;
      @(posedge clk);
    end
    raw.valid      <= 1'b1;
    raw.in_byte    <= b;
    raw.body_start <= first;
    do @(posedge clk); while (!raw.ready);
    predict_byte(b, first);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // Stops offering and waits until every due beat is back, then gives the
  // pipeline a few more cycles for bytes that produce no beat.
  task automatic settle();
    raw.valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_CHUNK_MODE) mode_on = val[0];
    else line_limit = val;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h37 : 8'h57) + 8'(n);
  endfunction

  // A size line for len: optional leading blanks, an optional leading zero,
  // the digits in one letter case, an optional extension, then CR LF.
  task automatic send_size_line(input logic [SIZE_WIDTH-1:0] len);
    logic [7:0] line[$];
    int         nd;
    bit         upper;
    nd = 1;
    for (int i = 1; i < SIZE_WIDTH / 4; i++) if ((len >> (4 * i)) != '0) nd = i + 1;
    upper = 1'($urandom_range(1));
    repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0)
      line.push_back(BLANKS[$urandom_range(3)]);
    if ($urandom_range(5) == 0) line.push_back(8'h30);
    for (int i = nd - 1; i >= 0; i--) line.push_back(hex_char(len[4*i +: 4], upper));
    if ($urandom_range(4) == 0) begin
      line.push_back(8'h3b);
      repeat ($urandom_range(3)) line.push_back(8'($urandom_range(8'h21, 8'h7e)));
    end
    line.push_back(BYTE_CR);
    line.push_back(BYTE_LF);
    foreach (line[i]) send_byte(line[i], 1'b0);
  endtask

  // Payload and trailer after a size line. If the line failed, there is
  // nothing to send and the next body starts over.
  task automatic send_chunk_body(input logic [SIZE_WIDTH-1:0] len);
    if (err_sticky || !in_data) begin
      restart_next = 1'b1;
      return;
    end
    repeat (len) send_byte(8'($urandom), 1'b0);
    if ($urandom_range(7) == 0) begin
      repeat (2) send_byte(8'($urandom), 1'b0);
    end else begin
      send_text(crlf);
    end
  endtask

  task automatic send_chunk(input logic [SIZE_WIDTH-1:0] len);
    send_size_line(len);
    send_chunk_body(len);
  endtask

  // Size line "1;aaa..." that is exactly total bytes long with its CR LF.
  task automatic send_padded_line(input int total);
    send_byte(8'h31, 1'b0);
    for (int k = 0; k < total - 3; k++) send_byte((k == 0) ? 8'h3b : 8'h61, 1'b0);
    send_text(crlf);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Short hand-made body: leading blanks, the payload byte extremes, a 0x
  // prefix that cuts the length to zero, a line with no digits at all, and
  // a length that overflows the size register.
  task automatic test_directed();
    restart_next = 1'b1;
    send_text({" \t3", crlf});
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h41, 1'b0);
    send_text(crlf);
    send_text({"0x5", crlf, crlf});
    // The first CR LF is skipped as blank; the second closes an empty line.
    send_text({crlf, crlf, crlf});
    // The ninth digit overflows; the trailing bytes fall on the held error.
    send_text({"100000000 ", crlf});
    restart_next = 1'b1;
  endtask

  // The receiver holds off for a long stretch while the sender keeps the raw
  // side busy, so the block fills and must stall its input. Afterwards the
  // sender pauses until every beat has drained.
  task automatic test_backpressure();
    int keep_pct;
    keep_pct = src_idle_pct;
    src_idle_pct = 0;
    restart_next = 1'b1;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    send_chunk(40);
    settle();
    send_chunk(6);
    settle();
    src_idle_pct = keep_pct;
  endtask

  // With decoding off every byte is dropped and the parse state kept, except
  // that body_start still clears it.
  task automatic test_mode_off();
    restart_next = 1'b1;
    send_text({"8", crlf, "abc"});
    write_cfg(CFG_CHUNK_MODE, 8'd0);
    repeat (20) send_byte(8'($urandom), 1'b0);
    write_cfg(CFG_CHUNK_MODE, 8'd1);
    send_text({"defgh", crlf});
    write_cfg(CFG_CHUNK_MODE, 8'd0);
    send_text({"4", crlf, "w"});
    send_byte(8'($urandom), 1'b1);
    repeat (10) send_byte(8'($urandom), 1'b0);
    write_cfg(CFG_CHUNK_MODE, 8'd1);
    send_chunk(5);
  endtask

  // For each line limit, a line that just fits and one that is a byte too
  // long. A limit below 3 leaves no room for any line to close.
  task automatic test_line_limit();
    logic [7:0] limits [4];
    limits = '{8'd2, 8'd3, 8'd255, 8'd16};
    foreach (limits[i]) begin
      write_cfg(CFG_MAX_LINE_LEN, limits[i]);
      restart_next = 1'b1;
      send_padded_line(int'(limits[i]));
      send_chunk_body(1);
      send_padded_line(int'(limits[i]) + 1);
      send_chunk_body(1);
      send_chunk(3);
    end
  endtask

  // One random piece of body: mostly well-formed chunks with random content,
  // the rest noise, overflowing or overlong lines, and chunks cut short.
  task automatic random_step();
    logic [SIZE_WIDTH-1:0] len;
    case ($urandom_range(19))
      0: begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(7) == 0);
        restart_next = 1'b1;
      end
      1: begin
        send_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(1))), 1'b0);
        repeat (8) send_byte(hex_char(4'($urandom), 1'($urandom_range(1))), 1'b0);
        send_text(crlf);
        restart_next = 1'b1;
      end
      2: begin
        send_padded_line((line_limit <= 8'd40) ? int'(line_limit) + 1 : $urandom_range(3, 40));
        send_chunk_body(1);
      end
      3: begin
        // A huge chunk that a new body interrupts.
        len = SIZE_WIDTH'($urandom) | (1 << (SIZE_WIDTH - 1));
        send_size_line(len);
        repeat ($urandom_range(5)) send_byte(8'($urandom), 1'b0);
        restart_next = 1'b1;
      end
      4, 5: send_chunk(0);
      default: send_chunk($urandom_range(1, 24));
    endcase
  endtask

  // Three rounds of random bodies, one per idling pattern, each with its
  // own line limit.
  task automatic test_random();
    int goal;
    int src_plan [3];
    int snk_plan [3];
    src_plan = '{26, 53, 0};
    snk_plan = '{53, 26, 0};
    for (int p = 0; p < 3; p++) begin
      src_idle_pct = src_plan[p];
      snk_idle_pct = snk_plan[p];
      case (p)
        0: write_cfg(CFG_MAX_LINE_LEN, 8'($urandom_range(12, 40)));
        1: write_cfg(CFG_MAX_LINE_LEN, 8'd16);
        default: write_cfg(CFG_MAX_LINE_LEN, 8'($urandom_range(5, 255)));
      endcase
      restart_next = 1'b1;
      goal = bytes_sent + 230;
      while (bytes_sent < goal) random_step();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run.
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_index      = CFG_CHUNK_MODE;
    cfg_wdata      = '0;
    raw.valid      = 1'b0;
    raw.in_byte    = '0;
    raw.body_start = 1'b0;
    dec.ready      = 1'b0;
    rx_hold        = 1'b0;
    restart_next   = 1'b0;
    bytes_sent     = 0;
    n_fail         = 0;
    mode_on        = 1'b1;
    line_limit     = 8'd16;
    restart_body();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_mode_off();
    test_line_limit();
    test_random();

    // Everything sent: wait for the last beats, then a few quiet cycles to
    // catch anything the block might still emit.
    settle();
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // A hung handshake or a beat that never comes ends the run here.
  initial begin
    #1600000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> http_chunked_body_decoder.f
rtl/hcbd_pkg.sv
rtl/hcbd_raw_if.sv
rtl/hcbd_dec_if.sv
rtl/hcbd_in_stage.sv
rtl/hcbd_core.sv
rtl/http_chunked_body_decoder.sv
dv/tb.sv
